FILE: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk, off while rst_n is low.
`define RRV_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rrv: implication check failed");

// Next-cycle implication, checked on clk, off while rst_n is low.
`define RRV_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rrv: next-cycle check failed");

`endif

FILE: rtl/core/rrv_pkg.sv
`default_nettype none

package rrv_pkg;

    localparam int CFG_W            = 15;
    localparam int CFG_IDX_W        = 2;
    localparam int DIST_W           = 16;
    localparam int VEL_W            = 16;
    localparam int SUM_W            = VEL_W + 2;
    localparam int QUOT_W           = 15;
    localparam int PROD_W           = 2 * QUOT_W;
    localparam int LANE_LAT         = QUOT_W + 2;
    localparam int SENSOR_N         = 6;
    localparam int MAX_RANGE_MM_DEF = 2000;

    // sensor lane order
    localparam int S_FRONT  = 0;
    localparam int S_RIGHT  = 1;
    localparam int S_BACK   = 2;
    localparam int S_LEFT   = 3;
    localparam int S_BOTTOM = 4;
    localparam int S_TOP    = 5;

    localparam logic [CFG_W-1:0] INNER_RST   = 15'd1000;
    localparam logic [CFG_W-1:0] OUTER_RST   = 15'd1400;
    localparam logic [CFG_W-1:0] MIN_VEL_RST = 15'd0;
    localparam logic [CFG_W-1:0] MAX_VEL_RST = 15'd500;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INNER   = 2'd0,
        CFG_OUTER   = 2'd1,
        CFG_MIN_VEL = 2'd2,
        CFG_MAX_VEL = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        PUSH_NONE,
        PUSH_FULL,
        PUSH_RAMP
    } push_mode_t;

    typedef struct packed {
        logic [CFG_W-1:0] inner;
        logic [CFG_W-1:0] outer;
        logic [CFG_W-1:0] min_vel;
        logic [CFG_W-1:0] max_vel;
    } cfg_t;

    typedef struct packed {
        logic signed [VEL_W-1:0] x;
        logic signed [VEL_W-1:0] y;
        logic signed [VEL_W-1:0] z;
    } vel_t;

endpackage

`default_nettype wire

FILE: rtl/core/range_repulsion_velocity.sv
// Channel   | Handshake          | Payload
// ----------+--------------------+---------------------------------------------
// item in   | start, busy        | dist_front..dist_top, want_vel_x/y/z
// result    | done (one cycle)   | out_vel_x, out_vel_y, out_vel_z
// config    | cfg_we             | cfg_index, cfg_data (15 bits)
//
// One item per cycle, back to back; each result passes through registered stages
// after its item is taken (1 classify + 1 multiply + 15 divider stages + 1 merge).
// The per-lane divider produces one quotient bit per stage.
// busy is high during reset and until the clock edge that follows its release.
// Reset sets the config registers to their defaults and empties the pipeline.
// The receiver cannot stall: done marks a result valid for that cycle only.
`default_nettype none

`include "assert_macros.svh"

module range_repulsion_velocity #(
    parameter int MAX_RANGE_MM = rrv_pkg::MAX_RANGE_MM_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   start,
    output logic                                        busy,
    output logic                                        done,
    input  wire logic                                   cfg_we,
    input  wire logic [rrv_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [rrv_pkg::CFG_W-1:0]              cfg_data,
    input  wire logic signed [rrv_pkg::DIST_W-1:0]      dist_front,
    input  wire logic signed [rrv_pkg::DIST_W-1:0]      dist_right,
    input  wire logic signed [rrv_pkg::DIST_W-1:0]      dist_back,
    input  wire logic signed [rrv_pkg::DIST_W-1:0]      dist_left,
    input  wire logic signed [rrv_pkg::DIST_W-1:0]      dist_bottom,
    input  wire logic signed [rrv_pkg::DIST_W-1:0]      dist_top,
    input  wire logic signed [rrv_pkg::VEL_W-1:0]       want_vel_x,
    input  wire logic signed [rrv_pkg::VEL_W-1:0]       want_vel_y,
    input  wire logic signed [rrv_pkg::VEL_W-1:0]       want_vel_z,
    output logic signed [rrv_pkg::VEL_W-1:0]            out_vel_x,
    output logic signed [rrv_pkg::VEL_W-1:0]            out_vel_y,
    output logic signed [rrv_pkg::VEL_W-1:0]            out_vel_z
);

    localparam int LAT = rrv_pkg::LANE_LAT;

    logic                                   fire;
    logic                                   busy_reg;
    logic                                   busy_next;
    logic [LAT:0]                           vld_reg;
    logic [LAT:0]                           vld_next;
    rrv_pkg::cfg_t                          cfg_reg;
    rrv_pkg::cfg_t                          cfg_next;
    rrv_pkg::vel_t                          vel_reg [0:LAT-1];
    logic signed [rrv_pkg::DIST_W-1:0]      dist_lane [rrv_pkg::SENSOR_N];
    logic signed [rrv_pkg::VEL_W-1:0]       push_lane [rrv_pkg::SENSOR_N];

    // take an item whenever start is up and the reset settle cycle is over
    assign fire = start && !busy_reg;
    assign busy = busy_reg;
    assign done = vld_reg[LAT];

    assign busy_next = 1'b0;
    assign vld_next  = {vld_reg[LAT-1:0], fire};

    // register write: a write lands in the addressed register only
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (rrv_pkg::cfg_idx_t'(cfg_index))
                rrv_pkg::CFG_INNER:   cfg_next.inner   = cfg_data;
                rrv_pkg::CFG_OUTER:   cfg_next.outer   = cfg_data;
                rrv_pkg::CFG_MIN_VEL: cfg_next.min_vel = cfg_data;
                rrv_pkg::CFG_MAX_VEL: cfg_next.max_vel = cfg_data;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg        <= 1'b1;
            vld_reg         <= '0;
            cfg_reg.inner   <= rrv_pkg::INNER_RST;
            cfg_reg.outer   <= rrv_pkg::OUTER_RST;
            cfg_reg.min_vel <= rrv_pkg::MIN_VEL_RST;
            cfg_reg.max_vel <= rrv_pkg::MAX_VEL_RST;
        end
        else
        begin
            busy_reg <= busy_next;
            vld_reg  <= vld_next;
            cfg_reg  <= cfg_next;
        end
    end

    // hold the intended velocity alongside the lanes until the merge stage
    always_ff @(posedge clk)
    begin
        vel_reg[0] <= '{x: want_vel_x, y: want_vel_y, z: want_vel_z};
        for (int i = 1; i < LAT; i++)
            vel_reg[i] <= vel_reg[i-1];
    end

    assign dist_lane[rrv_pkg::S_FRONT]  = dist_front;
    assign dist_lane[rrv_pkg::S_RIGHT]  = dist_right;
    assign dist_lane[rrv_pkg::S_BACK]   = dist_back;
    assign dist_lane[rrv_pkg::S_LEFT]   = dist_left;
    assign dist_lane[rrv_pkg::S_BOTTOM] = dist_bottom;
    assign dist_lane[rrv_pkg::S_TOP]    = dist_top;

    // one lane per sensor; all lanes run in lock step with the valid line
    for (genvar s = 0; s < rrv_pkg::SENSOR_N; s++)
    begin : g_lane
        rrv_lane #(
            .MAX_RANGE_MM (MAX_RANGE_MM)
        ) u_lane (
            .clk     (clk),
            .cfg     (cfg_reg),
            .reading (dist_lane[s]),
            .push    (push_lane[s])
        );
    end

    rrv_merge u_merge (
        .clk   (clk),
        .vel   (vel_reg[LAT-1]),
        .push  (push_lane),
        .out_x (out_vel_x),
        .out_y (out_vel_y),
        .out_z (out_vel_z)
    );

    // every result traces back to an item taken a fixed latency earlier
    `RRV_ASSERT_IMP(a_done_has_item, done, $past(start && !busy, LAT + 1))
    // every item taken comes out after the fixed latency
    `RRV_ASSERT_IMP(a_item_gives_done, fire, ##(LAT + 1) done)
    // once the settle cycle is over the block never holds items off
    `RRV_ASSERT_NXT(a_busy_stays_low, !busy, !busy)

endmodule

`default_nettype wire

FILE: rtl/core/rrv_lane.sv
`default_nettype none

// One sensor: classify the reading, form |max-min|*(outer-r), then divide by
// (outer-inner) one quotient bit per stage.
module rrv_lane #(
    parameter int MAX_RANGE_MM = rrv_pkg::MAX_RANGE_MM_DEF
) (
    input  wire logic                                 clk,
    input  wire rrv_pkg::cfg_t                        cfg,
    input  wire logic signed [rrv_pkg::DIST_W-1:0]    reading,
    output logic signed [rrv_pkg::VEL_W-1:0]          push
);

    localparam int Q = rrv_pkg::QUOT_W;
    localparam int P = rrv_pkg::PROD_W;

    logic                              in_range;
    logic [Q-1:0]                      r15;
    logic signed [rrv_pkg::VEL_W-1:0]  dv;
    logic [Q-1:0]                      div_d;
    logic [Q-1:0]                      quot;

    rrv_pkg::push_mode_t               a_mode_next;
    rrv_pkg::push_mode_t               a_mode_reg;
    logic                              a_neg_reg;
    logic [Q-1:0]                      a_mag_reg;
    logic [Q-1:0]                      a_t_reg;

    logic [P-1:0]                      w_reg    [0:Q];
    rrv_pkg::push_mode_t               mode_reg [0:Q];
    logic                              neg_reg  [0:Q];

    assign div_d = cfg.outer - cfg.inner;
    assign r15   = reading[Q-1:0];
    assign dv    = $signed({1'b0, cfg.max_vel}) - $signed({1'b0, cfg.min_vel});

    always_comb
    begin
        in_range = (reading >= 16'sd1) &&
                   (reading <= $signed(rrv_pkg::DIST_W'(MAX_RANGE_MM)));
        if (!in_range)
            a_mode_next = rrv_pkg::PUSH_NONE;
        else if (r15 < cfg.inner)
            a_mode_next = rrv_pkg::PUSH_FULL;
        else if (r15 < cfg.outer)
            a_mode_next = rrv_pkg::PUSH_RAMP;
        else
            a_mode_next = rrv_pkg::PUSH_NONE;
    end

    always_ff @(posedge clk)
    begin
        a_mode_reg  <= a_mode_next;
        a_neg_reg   <= dv[rrv_pkg::VEL_W-1];
        a_mag_reg   <= dv[rrv_pkg::VEL_W-1] ? Q'(-dv) : Q'(dv);
        a_t_reg     <= cfg.outer - r15;
        w_reg[0]    <= P'(a_mag_reg) * P'(a_t_reg);
        mode_reg[0] <= a_mode_reg;
        neg_reg[0]  <= a_neg_reg;
    end

    // restoring division: the product is below div_d << Q, so the top Q bits
    // start as a valid partial remainder
    for (genvar k = 0; k < Q; k++)
    begin : g_div
        logic [Q:0] part;
        logic [Q:0] diff;
        logic       ge;

        assign part = w_reg[k][P-1:Q-1];
        assign diff = part - {1'b0, div_d};
        assign ge   = (part >= {1'b0, div_d});

        always_ff @(posedge clk)
        begin
            w_reg[k+1]    <= {(ge ? diff[Q-1:0] : part[Q-1:0]), w_reg[k][Q-2:0], ge};
            mode_reg[k+1] <= mode_reg[k];
            neg_reg[k+1]  <= neg_reg[k];
        end
    end

    assign quot = w_reg[Q][Q-1:0];

    always_comb
    begin
        unique case (mode_reg[Q])
            rrv_pkg::PUSH_FULL: push = $signed({1'b0, cfg.max_vel});
            rrv_pkg::PUSH_RAMP: push = neg_reg[Q] ? -$signed({1'b0, quot})
                                                  : $signed({1'b0, quot});
            default:            push = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/rrv_merge.sv
`default_nettype none

// Combine lane pushes with the intended velocity and saturate each axis.
module rrv_merge (
    input  wire logic                              clk,
    input  wire rrv_pkg::vel_t                     vel,
    input  wire logic signed [rrv_pkg::VEL_W-1:0]  push [rrv_pkg::SENSOR_N],
    output logic signed [rrv_pkg::VEL_W-1:0]       out_x,
    output logic signed [rrv_pkg::VEL_W-1:0]       out_y,
    output logic signed [rrv_pkg::VEL_W-1:0]       out_z
);

    localparam int S = rrv_pkg::SUM_W;
    localparam int V = rrv_pkg::VEL_W;

    logic signed [S-1:0] sum_x;
    logic signed [S-1:0] sum_y;
    logic signed [S-1:0] sum_z;

    function automatic logic signed [V-1:0] sat(input logic signed [S-1:0] v);
        logic signed [S-1:0] hi;
        logic signed [S-1:0] lo;
        hi = S'($signed({1'b0, {(V-1){1'b1}}}));
        lo = -hi - S'(1);
        if (v > hi)
            sat = hi[V-1:0];
        else if (v < lo)
            sat = lo[V-1:0];
        else
            sat = v[V-1:0];
    endfunction

    assign sum_x = S'(vel.x) - S'(push[rrv_pkg::S_FRONT]) + S'(push[rrv_pkg::S_BACK]);
    assign sum_y = S'(vel.y) - S'(push[rrv_pkg::S_RIGHT]) + S'(push[rrv_pkg::S_LEFT]);
    assign sum_z = S'(vel.z) - S'(push[rrv_pkg::S_TOP]) + S'(push[rrv_pkg::S_BOTTOM]);

    always_ff @(posedge clk)
    begin
        out_x <= sat(sum_x);
        out_y <= sat(sum_y);
        out_z <= sat(sum_z);
    end

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import rrv_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int RANGE_LIMIT = MAX_RANGE_MM_DEF;
    // Idle cycles required before a register write or after a pause.
    localparam int QUIET_CYC   = 4;
    localparam int CYCLE_LIMIT = 400000;

    // One sensor sample set plus the wanted body velocity.
    typedef struct packed {
        logic signed [DIST_W-1:0] front;
        logic signed [DIST_W-1:0] right;
        logic signed [DIST_W-1:0] back;
        logic signed [DIST_W-1:0] left;
        logic signed [DIST_W-1:0] bottom;
        logic signed [DIST_W-1:0] top;
        vel_t                     want;
    } sample_t;

    // What the driver does next: send an item, write a register, or pause
    // until every velocity in flight has come back.
    typedef enum logic [1:0] {
        CMD_ITEM,
        CMD_WRITE,
        CMD_PAUSE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [4:0]  gap;
        sample_t     set;
        cfg_idx_t    idx;
        logic [CFG_W-1:0] data;
    } cmd_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                     start     = 1'b0;
    logic                     busy;
    logic                     done;
    logic                     cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_W-1:0]         cfg_data  = '0;
    logic signed [DIST_W-1:0] dist_front  = '0;
    logic signed [DIST_W-1:0] dist_right  = '0;
    logic signed [DIST_W-1:0] dist_back   = '0;
    logic signed [DIST_W-1:0] dist_left   = '0;
    logic signed [DIST_W-1:0] dist_bottom = '0;
    logic signed [DIST_W-1:0] dist_top    = '0;
    logic signed [VEL_W-1:0]  want_vel_x  = '0;
    logic signed [VEL_W-1:0]  want_vel_y  = '0;
    logic signed [VEL_W-1:0]  want_vel_z  = '0;
    logic signed [VEL_W-1:0]  out_vel_x;
    logic signed [VEL_W-1:0]  out_vel_y;
    logic signed [VEL_W-1:0]  out_vel_z;

    cmd_t    pending_cmds [$];   // filled up front by the stimulus block
    vel_t    expected_vel [$];   // one entry per accepted item, oldest first
    cfg_t    live_regs;          // register copy the predictor works from
    cfg_t    plan_regs;          // register values the stimulus aims at
    sample_t drv_set;            // the item currently on the input ports
    int      gap_left  = 0;
    bit      gap_taken = 1'b0;
    int      quiet_cnt = 0;
    int      fails     = 0;
    int      cycles    = 0;

    range_repulsion_velocity #(
        .MAX_RANGE_MM (RANGE_LIMIT)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .done        (done),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .dist_front  (dist_front),
        .dist_right  (dist_right),
        .dist_back   (dist_back),
        .dist_left   (dist_left),
        .dist_bottom (dist_bottom),
        .dist_top    (dist_top),
        .want_vel_x  (want_vel_x),
        .want_vel_y  (want_vel_y),
        .want_vel_z  (want_vel_z),
        .out_vel_x   (out_vel_x),
        .out_vel_y   (out_vel_y),
        .out_vel_z   (out_vel_z)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Push of one range reading under the current registers. Readings out of
    // 1..RANGE_LIMIT count for nothing; below the inner border the push is the
    // full max velocity; inside the ramp it is the scaled difference with the
    // quotient truncated toward zero (negative when min exceeds max).
    function automatic longint repel_push(logic signed [DIST_W-1:0] reading);
        longint r;
        longint inner;
        longint outer;
        longint num;
        r     = reading;
        inner = live_regs.inner;
        outer = live_regs.outer;
        if (r < 1 || r > RANGE_LIMIT)
            return 0;
        if (r < inner)
            return live_regs.max_vel;
        if (r < outer)
        begin
            num = (longint'(live_regs.max_vel) - longint'(live_regs.min_vel)) * (outer - r);
            return num / (outer - inner);
        end
        return 0;
    endfunction

    function automatic logic signed [VEL_W-1:0] clamp_vel(longint v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return VEL_W'(v);
    endfunction

    // Sum each axis exactly, saturate only the final value.
    function automatic vel_t predict_vel(sample_t s);
        vel_t v;
        v.x = clamp_vel(longint'($signed(s.want.x)) - repel_push(s.front)
                        + repel_push(s.back));
        v.y = clamp_vel(longint'($signed(s.want.y)) - repel_push(s.right)
                        + repel_push(s.left));
        v.z = clamp_vel(longint'($signed(s.want.z)) - repel_push(s.top)
                        + repel_push(s.bottom));
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Driver: take commands from pending_cmds, one per free slot
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : feed_proc
        cmd_t cmd;
        logic go;
        logic wr;
        go = start;
        wr = 1'b0;
        if (!rst_n)
        begin
            live_regs.inner   = INNER_RST;
            live_regs.outer   = OUTER_RST;
            live_regs.min_vel = MIN_VEL_RST;
            live_regs.max_vel = MAX_VEL_RST;
            quiet_cnt         = 0;
        end
        else
        begin
            // Count edges with nothing on the ports and nothing in flight.
            if (start || expected_vel.size() != 0)
                quiet_cnt = 0;
            else
                quiet_cnt = quiet_cnt + 1;

            // Item taken at this edge: record its expected velocity.
            if (start && !busy)
            begin
                expected_vel.push_back(predict_vel(drv_set));
                go = 1'b0;
            end

            // Hold the item while busy; otherwise pick the next command.
            if (!go)
            begin
                if (gap_left != 0)
                    gap_left = gap_left - 1;
                else if (pending_cmds.size() != 0)
                begin
                    case (pending_cmds[0].kind)
                        CMD_ITEM:
                        begin
                            if (pending_cmds[0].gap != 0 && !gap_taken)
                            begin
                                // This cycle is the first of the idle burst.
                                gap_left  = pending_cmds[0].gap - 1;
                                gap_taken = 1'b1;
                            end
                            else
                            begin
                                cmd         = pending_cmds.pop_front();
                                gap_taken   = 1'b0;
                                drv_set     = cmd.set;
                                go          = 1'b1;
                                dist_front  <= cmd.set.front;
                                dist_right  <= cmd.set.right;
                                dist_back   <= cmd.set.back;
                                dist_left   <= cmd.set.left;
                                dist_bottom <= cmd.set.bottom;
                                dist_top    <= cmd.set.top;
                                want_vel_x  <= cmd.set.want.x;
                                want_vel_y  <= cmd.set.want.y;
                                want_vel_z  <= cmd.set.want.z;
                            end
                        end
                        CMD_WRITE:
                        begin
                            // Write only with the pipeline drained.
                            if (quiet_cnt >= QUIET_CYC)
                            begin
                                cmd       = pending_cmds.pop_front();
                                wr        = 1'b1;
                                cfg_index <= cmd.idx;
                                cfg_data  <= cmd.data;
                                case (cmd.idx)
                                    CFG_INNER:   live_regs.inner   = cmd.data;
                                    CFG_OUTER:   live_regs.outer   = cmd.data;
                                    CFG_MIN_VEL: live_regs.min_vel = cmd.data;
                                    CFG_MAX_VEL: live_regs.max_vel = cmd.data;
                                    default:     ;
                                endcase
                            end
                        end
                        CMD_PAUSE:
                        begin
                            if (quiet_cnt >= QUIET_CYC)
                                cmd = pending_cmds.pop_front();
                        end
                        default:
                            cmd = pending_cmds.pop_front();
                    endcase
                end
            end
        end
        start  <= go;
        cfg_we <= wr;
    end

    // ------------------------------------------------------------------
    // Monitor: compare each strobed velocity with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_proc
        vel_t exp_v;
        if (rst_n && done === 1'b1)
        begin
            if (expected_vel.size() == 0)
            begin
                $error("unexpected velocity x=%0d y=%0d z=%0d",
                       out_vel_x, out_vel_y, out_vel_z);
                fails = fails + 1;
            end
            else
            begin
                exp_v = expected_vel.pop_front();
                if (out_vel_x !== exp_v.x)
                begin
                    $error("out_vel_x: expected %0d, got %0d", exp_v.x, out_vel_x);
                    fails = fails + 1;
                end
                if (out_vel_y !== exp_v.y)
                begin
                    $error("out_vel_y: expected %0d, got %0d", exp_v.y, out_vel_y);
                    fails = fails + 1;
                end
                if (out_vel_z !== exp_v.z)
                begin
                    $error("out_vel_z: expected %0d, got %0d", exp_v.z, out_vel_z);
                    fails = fails + 1;
                end
            end
        end
    end

    // Watchdog: drop the run if it hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic sample_t make_set(int f, int r, int b, int l, int bo, int t,
                                         int vx, int vy, int vz);
        sample_t s;
        s.front  = DIST_W'(f);
        s.right  = DIST_W'(r);
        s.back   = DIST_W'(b);
        s.left   = DIST_W'(l);
        s.bottom = DIST_W'(bo);
        s.top    = DIST_W'(t);
        s.want.x = VEL_W'(vx);
        s.want.y = VEL_W'(vy);
        s.want.z = VEL_W'(vz);
        return s;
    endfunction

    task automatic add_item(sample_t s, logic [4:0] gap);
        cmd_t c;
        c      = '0;
        c.kind = CMD_ITEM;
        c.gap  = gap;
        c.set  = s;
        pending_cmds.push_back(c);
    endtask

    task automatic add_pause();
        cmd_t c;
        c      = '0;
        c.kind = CMD_PAUSE;
        pending_cmds.push_back(c);
    endtask

    task automatic add_write(cfg_idx_t idx, logic [CFG_W-1:0] data);
        cmd_t c;
        c      = '0;
        c.kind = CMD_WRITE;
        c.idx  = idx;
        c.data = data;
        pending_cmds.push_back(c);
    endtask

    // Write all four registers; every write waits for a drained pipeline.
    task automatic add_config(int inner, int outer, int min_v, int max_v);
        plan_regs.inner   = CFG_W'(inner);
        plan_regs.outer   = CFG_W'(outer);
        plan_regs.min_vel = CFG_W'(min_v);
        plan_regs.max_vel = CFG_W'(max_v);
        add_write(CFG_INNER,   plan_regs.inner);
        add_write(CFG_OUTER,   plan_regs.outer);
        add_write(CFG_MIN_VEL, plan_regs.min_vel);
        add_write(CFG_MAX_VEL, plan_regs.max_vel);
    endtask

    // Same reading on all six sensors, zero wanted velocity.
    task automatic add_sweep(int d);
        add_item(make_set(d, d, d, d, d, d, 0, 0, 0), '0);
    endtask

    // Readings weighted toward the borders and the validity limits.
    function automatic logic signed [DIST_W-1:0] rand_dist();
        case ($urandom_range(0, 9))
            0: return DIST_W'($urandom);
            1:
            begin
                case ($urandom_range(0, 6))
                    0:       return 16'sd0;
                    1:       return 16'sd1;
                    2:       return 16'sd2000;
                    3:       return 16'sd2001;
                    4:       return -16'sd1;
                    5:       return 16'sh8000;
                    default: return 16'sh7fff;
                endcase
            end
            2: return DIST_W'(int'(plan_regs.inner) + int'($urandom_range(0, 6)) - 3);
            3: return DIST_W'(int'(plan_regs.outer) + int'($urandom_range(0, 6)) - 3);
            4: return DIST_W'(-int'($urandom_range(0, 300)));
            default: return DIST_W'($urandom_range(1, RANGE_LIMIT));
        endcase
    endfunction

    // Velocities: full range, near both rails, and ordinary flight values.
    function automatic logic signed [VEL_W-1:0] rand_vel();
        case ($urandom_range(0, 7))
            0, 1: return VEL_W'($urandom);
            2:    return 16'sh7fff - VEL_W'($urandom_range(0, 800));
            3:    return 16'sh8000 + VEL_W'($urandom_range(0, 800));
            default: return VEL_W'(int'($urandom_range(0, 4000)) - 2000);
        endcase
    endfunction

    // Random items; with idling set, idle bursts fall only in every other stretch
    // of 32 items, and one pause in the middle drains the pipeline.
    task automatic add_random(int count, bit idling);
        sample_t    s;
        logic [4:0] gap;
        for (int k = 0; k < count; k++)
        begin
            s.front  = rand_dist();
            s.right  = rand_dist();
            s.back   = rand_dist();
            s.left   = rand_dist();
            s.bottom = rand_dist();
            s.top    = rand_dist();
            s.want.x = rand_vel();
            s.want.y = rand_vel();
            s.want.z = rand_vel();
            gap = '0;
            if (idling && ((k / 32) % 2 == 0) && $urandom_range(0, 5) == 0)
                gap = 5'($urandom_range(1, 16));
            add_item(s, gap);
            if (k == count / 2)
                add_pause();
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        plan_regs.inner   = INNER_RST;
        plan_regs.outer   = OUTER_RST;
        plan_regs.min_vel = MIN_VEL_RST;
        plan_regs.max_vel = MAX_VEL_RST;

        // Directed items under the reset registers (1000, 1400, 0, 500).
        // Invalid readings everywhere: zero, negative, above the range limit.
        add_item(make_set(0, 0, 0, 0, 0, 0, 0, 0, 0), '0);
        add_item(make_set(-32768, -32768, -32768, -32768, -32768, -32768,
                          32767, -32768, 0), '0);
        add_item(make_set(2001, 2001, 2001, 2001, 2001, 2001, -1, 1, -1), '0);
        add_item(make_set(32767, 32767, 32767, 32767, 32767, 32767, 0, 0, 0), '0);
        add_item(make_set(-1, -1, -1, -1, -1, -1, 7, 7, 7), '0);
        // Each sensor alone, then bottom and top together, across full push, ramp and no push.
        add_item(make_set(1, 0, 0, 0, 0, 0, 100, 0, 0), '0);
        add_item(make_set(0, 999, 0, 0, 0, 0, 0, 100, 0), '0);
        add_item(make_set(0, 0, 1000, 0, 0, 0, 0, 0, 0), '0);
        add_item(make_set(0, 0, 0, 1399, 0, 0, 0, 0, 0), '0);
        add_item(make_set(0, 0, 0, 0, 1400, 0, 0, 0, 0), '0);
        add_item(make_set(0, 0, 0, 0, 0, 2000, 0, 0, 0), '0);
        add_item(make_set(0, 0, 0, 0, 1200, 500, 0, 0, 0), '0);
        // Ramp quotients that truncate.
        add_item(make_set(1001, 1333, 1399, 1001, 1111, 1257, 0, 0, 0), '0);
        // Saturation at both rails on all axes together, then pushes that cancel.
        add_item(make_set(0, 0, 10, 10, 10, 0, 32767, 32767, 32767), '0);
        add_item(make_set(10, 10, 0, 0, 0, 10, -32768, -32768, -32768), '0);
        add_item(make_set(10, 10, 10, 10, 10, 10, 32767, -32768, 32767), '0);
        add_item(make_set(1, 1, 1, 1, 1, 1, 0, 0, 0), '0);
        add_item(make_set(2000, 2000, 2000, 2000, 2000, 2000, -32768, -32768, -32768), '0);
        add_random(120, 1'b1);

        // Extreme registers: ramp covers every valid reading, pushes near the rail.
        add_config(0, 32767, 0, 32767);
        add_sweep(1);
        add_sweep(2000);
        add_item(make_set(1, 0, 0, 0, 0, 1, -32768, 0, -32768), '0);
        add_random(100, 1'b1);

        // Borders crossed: empty ramp, only full pushes below inner.
        add_config(1500, 300, 100, 800);
        add_sweep(299);
        add_sweep(300);
        add_sweep(1499);
        add_sweep(1500);
        add_random(80, 1'b1);

        // Min above max: the ramp draws toward the obstacle.
        add_config(200, 1800, 32767, 0);
        add_sweep(199);
        add_sweep(200);
        add_item(make_set(201, 1799, 999, 1000, 1333, 1777, 0, 0, 0), '0);
        add_random(80, 1'b1);

        // Equal borders.
        add_config(1000, 1000, 250, 250);
        add_sweep(999);
        add_sweep(1000);
        add_random(60, 1'b1);

        // Everything at the top of the register range.
        add_config(32767, 32767, 32767, 32767);
        add_random(60, 1'b1);

        // Everything zero.
        add_config(0, 0, 0, 0);
        add_random(40, 1'b1);

        // A few arbitrary settings.
        repeat (3)
        begin
            add_config($urandom_range(0, 2200), $urandom_range(0, 2600),
                       $urandom_range(0, 1500), $urandom_range(0, 3000));
            add_random(80, 1'b1);
        end

        // Back to the reset values, full rate with no idle bursts, but for the one pause in the middle.
        add_config(INNER_RST, OUTER_RST, MIN_VEL_RST, MAX_VEL_RST);
        add_random(150, 1'b0);

        // Hold reset, then release it at a rising edge.
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every command is sent and every velocity is back.
        while (pending_cmds.size() != 0 || start || expected_vel.size() != 0)
            @(posedge clk);
        // Let a late or extra strobe show up before closing.
        repeat (LANE_LAT + 4) @(posedge clk);

        if (fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+rtl/core
rtl/core/rrv_pkg.sv
rtl/core/rrv_lane.sv
rtl/core/rrv_merge.sv
rtl/core/range_repulsion_velocity.sv
tb/testbench.sv
